[hw/rtl/nested_priority_interrupt_controller_top_defines.svh]
// Assertion macros for the interrupt controller.
// Used by the top level; no other dependencies.
`ifndef NESTED_PRIORITY_INTERRUPT_CONTROLLER_TOP_DEFINES_SVH
`define NESTED_PRIORITY_INTERRUPT_CONTROLLER_TOP_DEFINES_SVH
// Implication checked on every clock unless reset is high.
`define NPIC_ASSERT_IMP(label, clk, rst, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error(msg);
// Next-cycle implication.
`define NPIC_ASSERT_NXT(label, clk, rst, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error(msg);
`endif

[hw/rtl/npic_pkg.sv]
// Package for the interrupt controller: payload structs, codes, constants.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package npic_pkg;
  localparam logic [1:0] CMD_LEVEL = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_WRITE = 2'd2;

  localparam logic [2:0] REG_ID       = 3'd0;
  localparam logic [2:0] REG_FIQ_CON  = 3'd1;
  localparam logic [2:0] REG_IRQ_CON  = 3'd2;
  localparam logic [2:0] REG_IRQ_CUR  = 3'd3;
  localparam logic [2:0] REG_FIQ_CUR  = 3'd4;
  localparam logic [2:0] REG_IRQ_ACK  = 3'd5;
  localparam logic [2:0] REG_FIQ_ACK  = 3'd6;
  localparam logic [2:0] REG_LINE_CFG = 3'd7;

  localparam logic [31:0] ID_VALUE = 32'h0031_C011;
  localparam int MASK_SHIFT = 16;

  typedef struct packed {
    logic [1:0] cmd;
    logic [2:0] reg_req;
    logic [7:0] line;
    logic       level;
    logic [7:0] wr_priority;
    logic       wr_is_fiq;
  } npic_in_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        irq_request;
    logic        fiq_request;
    logic        bad_register;
  } npic_out_t;

  // Best candidate so far, kept by each side's tracker during a scan.
  typedef struct packed {
    logic       found;
    logic [7:0] num;
    logic [7:0] prio;
  } npic_cand_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH,
    ST_OUT
  } npic_state_t;
endpackage
`default_nettype wire

[hw/rtl/nested_priority_interrupt_controller_top.sv]
// One transaction at a time: a request is taken only in IDLE, then passes SCAN,
// FINISH and OUT; a stalled output holds off the next request. The pace is set
// by the ring of line cells, which rotates once fully to present every line to
// the winner trackers after each accepted request.
// Reset is synchronous: all lines, masks and stack depths clear at once.
`timescale 1ns / 1ps
`default_nettype none
`include "nested_priority_interrupt_controller_top_defines.svh"
module nested_priority_interrupt_controller_top
  import npic_pkg::*;
#(
  parameter int NUM_LINES     = 170,
  parameter int STACK_DEPTH   = 15,
  parameter int PRIORITY_BITS = 8
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire npic_in_t  in_data,
  output logic           out_valid,
  input  wire logic      out_stall,
  output npic_out_t      out_data
);
  localparam int CW = $clog2(NUM_LINES + 1);
  localparam int PB = PRIORITY_BITS;

  npic_state_t state, state_next;
  npic_in_t    req;
  logic [CW-1:0] cnt;
  logic [7:0]  head_num;
  logic        line_ok;
  logic        shift;
  logic [31:0] data_hold;
  logic        bad_hold;
  logic          cfg_fiq;
  logic [PB-1:0] cfg_prio;

  logic          lvl  [NUM_LINES];
  logic [PB-1:0] pri  [NUM_LINES];
  logic          fiq  [NUM_LINES];

  logic [PB-1:0] irq_mask, fiq_mask;
  npic_cand_t    irq_best, fiq_best;
  logic          irq_full, fiq_full;
  logic          is_rd;

  assign is_rd   = (req.cmd == CMD_READ);
  assign line_ok = (9'(req.line) < 9'(NUM_LINES));
  assign shift   = (state == ST_SCAN);
  assign in_stall = (state != ST_IDLE);
  assign out_valid = (state == ST_OUT);

  // Ring of line cells; cell 0 is the head, and the last cell is fed back from it.
  for (genvar i = 0; i < NUM_LINES; i++) begin : g_cell
    localparam int NX = (i == NUM_LINES - 1) ? 0 : i + 1;
    logic we, le;
    assign we = (state == ST_IDLE) && in_valid && (in_data.cmd == CMD_WRITE) &&
                (in_data.reg_req == REG_LINE_CFG) && (in_data.line == 8'(i));
    assign le = (state == ST_IDLE) && in_valid && (in_data.cmd == CMD_LEVEL) &&
                (in_data.line == 8'(i));
    npic_cell #(.PRIORITY_BITS(PB)) u_cell (
      .clk, .rst, .shift,
      .wr_en(we), .wr_level_en(le), .wr_level(in_data.level),
      .wr_prio(in_data.wr_priority[PB-1:0]), .wr_fiq(in_data.wr_is_fiq),
      .in_level(lvl[NX]), .in_prio(pri[NX]), .in_fiq(fiq[NX]),
      .level(lvl[i]), .prio(pri[i]), .to_fiq(fiq[i])
    );
  end

  assign head_num = 8'(cnt);

  // Per-side stacks and trackers; pops and base writes take effect in IDLE
  // before the rescan, which is then evaluated against the new mask; pushes come in FINISH.
  npic_side #(.STACK_DEPTH(STACK_DEPTH), .PRIORITY_BITS(PB)) u_irq (
    .clk, .rst, .scan_clear(state == ST_IDLE && in_valid),
    .scan_en(shift), .head_ok(lvl[0] && !fiq[0]), .head_num, .head_prio(pri[0]),
    .base_wr(state == ST_IDLE && in_valid && in_data.cmd == CMD_WRITE &&
             in_data.reg_req == REG_IRQ_CON),
    .base_val(in_data.wr_priority[PB-1:0]),
    .push(state == ST_FINISH && is_rd && req.reg_req == REG_IRQ_CUR),
    .pop(state == ST_IDLE && in_valid && in_data.cmd == CMD_WRITE &&
         in_data.reg_req == REG_IRQ_ACK),
    .mask(irq_mask), .best(irq_best), .full(irq_full)
  );
  npic_side #(.STACK_DEPTH(STACK_DEPTH), .PRIORITY_BITS(PB)) u_fiq (
    .clk, .rst, .scan_clear(state == ST_IDLE && in_valid),
    .scan_en(shift), .head_ok(lvl[0] && fiq[0]), .head_num, .head_prio(pri[0]),
    .base_wr(state == ST_IDLE && in_valid && in_data.cmd == CMD_WRITE &&
             in_data.reg_req == REG_FIQ_CON),
    .base_val(in_data.wr_priority[PB-1:0]),
    .push(state == ST_FINISH && is_rd && req.reg_req == REG_FIQ_CUR),
    .pop(state == ST_IDLE && in_valid && in_data.cmd == CMD_WRITE &&
         in_data.reg_req == REG_FIQ_ACK),
    .mask(fiq_mask), .best(fiq_best), .full(fiq_full)
  );

  // State register, request capture and scan counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (state == ST_IDLE) cnt <= '0;
      else if (shift) cnt <= cnt + CW'(1);
    end
    if (state == ST_IDLE && in_valid) req <= in_data;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (in_valid) state_next = ST_SCAN;
      ST_SCAN:   if (cnt == CW'(NUM_LINES - 1)) state_next = ST_FINISH;
      ST_FINISH: state_next = ST_OUT;
      ST_OUT:    if (!out_stall) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // Line config read: grab the addressed line as it passes the head.
  always_ff @(posedge clk) begin
    if (shift && (head_num == req.line)) begin
      cfg_prio <= pri[0];
      cfg_fiq  <= fiq[0];
    end
  end

  // Read data and error flag, fixed at the end of the scan. Push happens
  // at the same edge, so the request flags after the push need a rescan;
  // instead they are derived below from whether the push takes place.
  always_ff @(posedge clk) begin
    if (state == ST_FINISH) begin
      data_hold <= '0;
      bad_hold  <= 1'b0;
      case (req.cmd)
        CMD_LEVEL: ;
        CMD_READ: begin
          case (req.reg_req)
            REG_ID:      data_hold <= ID_VALUE;
            REG_FIQ_CON: data_hold <= (32'(fiq_mask) << MASK_SHIFT) |
                          (fiq_best.found ? {16'd0, fiq_best.prio, fiq_best.num} : 32'd0);
            REG_IRQ_CON: data_hold <= (32'(irq_mask) << MASK_SHIFT) |
                          (irq_best.found ? {16'd0, irq_best.prio, irq_best.num} : 32'd0);
            REG_IRQ_CUR: data_hold <= (irq_best.found && !irq_full) ?
                                      32'(irq_best.num) : 32'd0;
            REG_FIQ_CUR: data_hold <= (fiq_best.found && !fiq_full) ?
                                      32'(fiq_best.num) : 32'd0;
            REG_LINE_CFG: begin
              if (line_ok) data_hold <= {23'd0, cfg_fiq, 8'(cfg_prio)};
              else bad_hold <= 1'b1;
            end
            default: bad_hold <= 1'b1;
          endcase
        end
        CMD_WRITE: begin
          case (req.reg_req)
            REG_FIQ_CON, REG_IRQ_CON, REG_IRQ_ACK, REG_FIQ_ACK: ;
            REG_LINE_CFG: if (!line_ok) bad_hold <= 1'b1;
            default: bad_hold <= 1'b1;
          endcase
        end
        default: bad_hold <= 1'b1;
      endcase
    end
  end

  // Request flags: after a push the winner's priority becomes the mask,
  // and no line on that side can exceed it, so the side drops.
  logic irq_req_hold, fiq_req_hold;
  always_ff @(posedge clk) begin
    if (state == ST_FINISH) begin
      irq_req_hold <= irq_best.found &&
                      !(is_rd && req.reg_req == REG_IRQ_CUR && !irq_full);
      fiq_req_hold <= fiq_best.found &&
                      !(is_rd && req.reg_req == REG_FIQ_CUR && !fiq_full);
    end
  end

  assign out_data.read_data    = data_hold;
  assign out_data.bad_register = bad_hold;
  assign out_data.irq_request  = irq_req_hold;
  assign out_data.fiq_request  = fiq_req_hold;

  `NPIC_ASSERT_IMP(a_one_phase, clk, rst, out_valid, in_stall, "output while accepting")
  `NPIC_ASSERT_NXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid, "result dropped")
  `NPIC_ASSERT_IMP(a_scan_done, clk, rst, state == ST_FINISH, cnt == CW'(NUM_LINES), "ring not home")
endmodule
`default_nettype wire

[hw/rtl/npic_cell.sv]
// One line cell: holds level, priority and routing of one interrupt line,
// and passes the configuration of its upstream neighbor on each shift.
// Depends on npic_pkg.
`timescale 1ns / 1ps
`default_nettype none
module npic_cell
  import npic_pkg::*;
#(
  parameter int PRIORITY_BITS = 8
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     shift,
  input  wire logic                     wr_en,
  input  wire logic                     wr_level_en,
  input  wire logic                     wr_level,
  input  wire logic [PRIORITY_BITS-1:0] wr_prio,
  input  wire logic                     wr_fiq,
  input  wire logic                     in_level,
  input  wire logic [PRIORITY_BITS-1:0] in_prio,
  input  wire logic                     in_fiq,
  output logic                          level,
  output logic [PRIORITY_BITS-1:0]      prio,
  output logic                          to_fiq
);
  // Rotate with the ring, or take a direct write when parked at home.
  always_ff @(posedge clk) begin
    if (rst) begin
      level  <= 1'b0;
      prio   <= '0;
      to_fiq <= 1'b0;
    end else if (shift) begin
      level  <= in_level;
      prio   <= in_prio;
      to_fiq <= in_fiq;
    end else begin
      if (wr_level_en) level <= wr_level;
      if (wr_en) begin
        prio   <= wr_prio;
        to_fiq <= wr_fiq;
      end
    end
  end
endmodule
`default_nettype wire

[hw/rtl/npic_side.sv]
// Nesting stack and candidate tracker of one side (IRQ or FIQ).
// Depends on npic_pkg.
`timescale 1ns / 1ps
`default_nettype none
module npic_side
  import npic_pkg::*;
#(
  parameter int STACK_DEPTH   = 15,
  parameter int PRIORITY_BITS = 8
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     scan_clear,
  input  wire logic                     scan_en,
  input  wire logic                     head_ok,
  input  wire logic [7:0]               head_num,
  input  wire logic [PRIORITY_BITS-1:0] head_prio,
  input  wire logic                     base_wr,
  input  wire logic [PRIORITY_BITS-1:0] base_val,
  input  wire logic                     push,
  input  wire logic                     pop,
  output logic [PRIORITY_BITS-1:0]      mask,
  output npic_cand_t                    best,
  output logic                          full
);
  localparam int DW = $clog2(STACK_DEPTH + 1);
  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  logic [PRIORITY_BITS-1:0] stack [STACK_DEPTH];
  logic [PRIORITY_BITS-1:0] base;
  logic [DW-1:0]            depth;
  logic [DW-1:0]            top_idx;

  assign top_idx = depth - DW'(1);
  assign mask = (depth != '0) ? stack[top_idx[AW-1:0]] : base;
  assign full = (depth == DW'(STACK_DEPTH));

  // Stack pointer and base mask.
  always_ff @(posedge clk) begin
    if (rst) begin
      depth <= '0;
      base  <= '0;
    end else if (push && !full && best.found) begin
      depth <= depth + DW'(1);
    end else if (pop) begin
      if (depth != '0) depth <= depth - DW'(1);
      if (depth <= DW'(1)) base <= '0;
    end else if (base_wr) begin
      base <= base_val;
    end
  end

  // Stack entries hold no reset.
  always_ff @(posedge clk) begin
    if (push && !full && best.found) stack[depth[AW-1:0]] <= best.prio[PRIORITY_BITS-1:0];
  end

  // Keep the best line seen at the head of the ring; strict compare keeps
  // the lower line number on ties since lines arrive in ascending order.
  always_ff @(posedge clk) begin
    if (rst || scan_clear) begin
      best <= '0;
    end else if (scan_en && head_ok && (head_prio > mask) &&
                 (!best.found || head_prio > best.prio[PRIORITY_BITS-1:0])) begin
      best.found <= 1'b1;
      best.num   <= head_num;
      best.prio  <= 8'(head_prio);
    end
  end
endmodule
`default_nettype wire
